>>> rtl/cfsw_pkg.sv
package cfsw_pkg;

	localparam logic [4:0] PH_MAGIC   = 5'd0;
	localparam logic [4:0] PH_VERSION = 5'd1;
	localparam logic [4:0] PH_PCOUNT  = 5'd2;
	localparam logic [4:0] PH_PTAG    = 5'd3;
	localparam logic [4:0] PH_PBODY   = 5'd4;
	localparam logic [4:0] PH_ULEN    = 5'd5;
	localparam logic [4:0] PH_UTEXT   = 5'd6;
	localparam logic [4:0] PH_CHDR    = 5'd7;
	localparam logic [4:0] PH_IFACE   = 5'd8;
	localparam logic [4:0] PH_FCOUNT  = 5'd9;
	localparam logic [4:0] PH_FHDR    = 5'd10;
	localparam logic [4:0] PH_MCOUNT  = 5'd11;
	localparam logic [4:0] PH_MHDR    = 5'd12;
	localparam logic [4:0] PH_AHDR    = 5'd13;
	localparam logic [4:0] PH_FBODY   = 5'd14;
	localparam logic [4:0] PH_MBODY   = 5'd15;
	localparam logic [4:0] PH_TRAIL   = 5'd16;
	localparam logic [4:0] PH_STOP    = 5'd17;

	localparam logic [31:0] CLASS_MAGIC = 32'hCAFE_BABE;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_MAGIC = 2'd1;
	localparam logic [1:0] ERR_TAG   = 2'd2;

	localparam logic [7:0] TAG_UTF8   = 8'd1;
	localparam logic [7:0] TAG_INT    = 8'd3;
	localparam logic [7:0] TAG_FLOAT  = 8'd4;
	localparam logic [7:0] TAG_LONG   = 8'd5;
	localparam logic [7:0] TAG_DOUBLE = 8'd6;
	localparam logic [7:0] TAG_CLASS  = 8'd7;
	localparam logic [7:0] TAG_STRING = 8'd8;
	localparam logic [7:0] TAG_FREF   = 8'd9;
	localparam logic [7:0] TAG_MREF   = 8'd10;
	localparam logic [7:0] TAG_IMREF  = 8'd11;
	localparam logic [7:0] TAG_NAT    = 8'd12;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  region;
		logic [15:0] pool_index;
		logic [7:0]  pool_tag;
		logic        attr_body_first;
		logic        attr_body_last;
		logic [31:0] attr_length;
		logic [1:0]  error_code;
	} out_item_t;

endpackage

>>> rtl/cfsw_queue.sv
module cfsw_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cfsw_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output cfsw_pkg::in_item_t  out_item
);
	import cfsw_pkg::*;

	in_item_t       mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;
	logic           push, pop;

	assign in_ready  = (cnt_q != QAW'(0) + (QAW+1)'(QDEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_item  = mem_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAW+1)'(QDEPTH)) else $error("queue overflow");
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == (QAW+1)'(QDEPTH)) |-> !in_ready) else $error("full queue ready");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == $past(cnt_q) - 1'b1)) else $error("bad count");
endmodule

>>> rtl/cfsw_walker.sv
module cfsw_walker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                magic_check_enable,
	input  logic                in_valid,
	output logic                in_ready,
	input  cfsw_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output cfsw_pkg::out_item_t out_item
);
	import cfsw_pkg::*;

	logic [4:0]  phase_q;
	logic [3:0]  bcnt_q;
	logic [31:0] shift_q;
	logic [15:0] pcount_q, slot_q, items_q, attrs_q;
	logic [7:0]  tag_q;
	logic [31:0] left_q;
	logic        inm_q;
	logic [1:0]  serr_q;
	logic        ovalid_q;
	out_item_t   oitem_q;

	logic [4:0]  ph, n_ph;
	logic [3:0]  bc, n_bc, bci;
	logic [31:0] sh, n_sh, shin;
	logic [15:0] pc, n_pc, sl, n_sl, it, n_it, at, n_at;
	logic [7:0]  tg, n_tg;
	logic [31:0] lf, n_lf;
	logic        im, n_im;
	logic [1:0]  se, n_se;
	out_item_t   r;
	logic        take;
	logic [3:0]  psize;
	logic        bad_tag;
	logic [16:0] nslot;
	logic [15:0] it_dec, at_dec;

	assign in_ready  = !ovalid_q || out_ready;
	assign take      = in_valid && in_ready;
	assign out_valid = ovalid_q;
	assign out_item  = oitem_q;

	always_comb begin
		bad_tag = 1'b0;
		psize   = 4'd0;
		unique case (in_item.data_byte)
			TAG_LONG, TAG_DOUBLE: psize = 4'd8;
			TAG_INT, TAG_FLOAT, TAG_FREF, TAG_MREF, TAG_IMREF, TAG_NAT: psize = 4'd4;
			TAG_CLASS, TAG_STRING: psize = 4'd2;
			TAG_UTF8: psize = 4'd0;
			default: bad_tag = 1'b1;
		endcase
	end

	always_comb begin
		ph = phase_q; bc = bcnt_q; sh = shift_q; pc = pcount_q; sl = slot_q;
		tg = tag_q; it = items_q; at = attrs_q; lf = left_q; im = inm_q; se = serr_q;
		if (in_item.start_of_file) begin
			ph = PH_MAGIC; bc = '0; sh = '0; pc = '0; sl = '0;
			tg = '0; it = '0; at = '0; lf = '0; im = 1'b0; se = ERR_NONE;
		end
		n_ph = ph; n_bc = bc; n_sh = sh; n_pc = pc; n_sl = sl;
		n_tg = tg; n_it = it; n_at = at; n_lf = lf; n_im = im; n_se = se;
		shin   = {sh[23:0], in_item.data_byte};
		bci    = bc + 4'd1;
		nslot  = {1'b0, sl} + ((tg == TAG_LONG || tg == TAG_DOUBLE) ? 17'd2 : 17'd1);
		it_dec = it - 16'd1;
		at_dec = at - 16'd1;
		r = '0;
		r.region = ph;
		unique case (ph)
			PH_MAGIC: begin
				n_sh = shin; n_bc = bci;
				if (bci == 4'd4) begin
					n_bc = '0;
					if (magic_check_enable && shin != CLASS_MAGIC) begin
						r.error_code = ERR_MAGIC; n_se = ERR_MAGIC; n_ph = PH_STOP;
					end else begin
						n_ph = PH_VERSION;
					end
				end
			end
			PH_VERSION: begin
				n_bc = bci;
				if (bci == 4'd4) begin
					n_bc = '0; n_ph = PH_PCOUNT;
				end
			end
			PH_PCOUNT: begin
				n_sh = shin; n_bc = bci;
				if (bci == 4'd2) begin
					n_bc = '0; n_pc = shin[15:0]; n_sl = 16'd1;
					n_ph = (shin[15:0] > 16'd1) ? PH_PTAG : PH_CHDR;
				end
			end
			PH_PTAG: begin
				r.pool_index = sl; r.pool_tag = in_item.data_byte;
				n_tg = in_item.data_byte; n_bc = '0;
				if (bad_tag) begin
					r.error_code = ERR_TAG; n_se = ERR_TAG; n_ph = PH_STOP;
				end else if (in_item.data_byte == TAG_UTF8) begin
					n_ph = PH_ULEN;
				end else begin
					n_lf = {28'd0, psize}; n_ph = PH_PBODY;
				end
			end
			PH_PBODY, PH_UTEXT: begin
				r.pool_index = sl; r.pool_tag = tg;
				if (lf <= 32'd1) begin
					n_lf = '0; n_sl = nslot[15:0]; n_bc = '0;
					n_ph = (nslot < {1'b0, pc}) ? PH_PTAG : PH_CHDR;
				end else begin
					n_lf = lf - 32'd1;
				end
			end
			PH_ULEN: begin
				r.pool_index = sl; r.pool_tag = tg;
				n_sh = shin; n_bc = bci;
				if (bci == 4'd2) begin
					n_bc = '0; n_lf = {16'd0, shin[15:0]};
					if (shin[15:0] == 16'd0) begin
						n_sl = nslot[15:0];
						n_ph = (nslot < {1'b0, pc}) ? PH_PTAG : PH_CHDR;
					end else begin
						n_ph = PH_UTEXT;
					end
				end
			end
			PH_CHDR: begin
				n_sh = shin; n_bc = bci;
				if (bci == 4'd8) begin
					n_bc = '0; n_it = shin[15:0];
					n_ph = (shin[15:0] != 16'd0) ? PH_IFACE : PH_FCOUNT;
				end
			end
			PH_IFACE: begin
				n_bc = bci;
				if (bci == 4'd2) begin
					n_bc = '0; n_it = it_dec;
					if (it_dec == 16'd0) begin
						n_ph = PH_FCOUNT;
					end
				end
			end
			PH_FCOUNT, PH_MCOUNT: begin
				n_sh = shin; n_bc = bci;
				if (bci == 4'd2) begin
					n_bc = '0; n_it = shin[15:0]; n_im = (ph == PH_MCOUNT);
					if (shin[15:0] != 16'd0) begin
						n_ph = n_im ? PH_MHDR : PH_FHDR;
					end else begin
						n_ph = n_im ? PH_TRAIL : PH_MCOUNT;
					end
				end
			end
			PH_FHDR, PH_MHDR: begin
				n_sh = shin; n_bc = bci;
				if (bci == 4'd8) begin
					n_bc = '0; n_at = shin[15:0];
					if (shin[15:0] != 16'd0) begin
						n_ph = PH_AHDR;
					end else begin
						n_it = it_dec;
						if (it_dec != 16'd0) begin
							n_ph = im ? PH_MHDR : PH_FHDR;
						end else begin
							n_ph = im ? PH_TRAIL : PH_MCOUNT;
						end
					end
				end
			end
			PH_AHDR: begin
				n_sh = shin; n_bc = bci;
				if (bci == 4'd6) begin
					n_bc = '0; r.attr_length = shin; n_lf = shin;
					if (shin == 32'd0) begin
						n_at = at_dec;
						if (at_dec != 16'd0) begin
							n_ph = PH_AHDR;
						end else begin
							n_it = it_dec;
							if (it_dec != 16'd0) begin
								n_ph = im ? PH_MHDR : PH_FHDR;
							end else begin
								n_ph = im ? PH_TRAIL : PH_MCOUNT;
							end
						end
					end else begin
						n_ph = im ? PH_MBODY : PH_FBODY;
					end
				end
			end
			PH_FBODY, PH_MBODY: begin
				r.attr_length     = sh;
				r.attr_body_first = (lf == sh);
				r.attr_body_last  = (lf <= 32'd1);
				if (lf <= 32'd1) begin
					n_lf = '0; n_at = at_dec;
					if (at_dec != 16'd0) begin
						n_ph = PH_AHDR;
					end else begin
						n_it = it_dec;
						if (it_dec != 16'd0) begin
							n_ph = im ? PH_MHDR : PH_FHDR;
						end else begin
							n_ph = im ? PH_TRAIL : PH_MCOUNT;
						end
					end
				end else begin
					n_lf = lf - 32'd1;
				end
			end
			PH_TRAIL: begin
			end
			default: begin
				r.region = PH_STOP; r.error_code = se;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC; bcnt_q <= '0; shift_q <= '0; pcount_q <= '0;
			slot_q <= '0; tag_q <= '0; items_q <= '0; attrs_q <= '0; left_q <= '0;
			inm_q <= 1'b0; serr_q <= ERR_NONE; ovalid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= n_ph; bcnt_q <= n_bc; shift_q <= n_sh; pcount_q <= n_pc;
				slot_q <= n_sl; tag_q <= n_tg; items_q <= n_it; attrs_q <= n_at;
				left_q <= n_lf; inm_q <= n_im; serr_q <= n_se;
			end
			if (take) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			oitem_q <= r;
		end
	end

	a_stop_err: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_STOP) |-> (serr_q != ERR_NONE)) else $error("stop without error");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !out_ready) |=> $stable(oitem_q)) else $error("result lost");
	a_bcnt: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q < 4'd8) else $error("byte count overrun");
endmodule

>>> rtl/class_file_structure_walker_top.sv
// Class file structure walker: takes a class file one byte per item and returns one
// classification per byte (region, pool slot and tag, attribute body marks and length,
// error code). Assert start_of_file on the first byte of each file. Throughput is one
// byte per cycle while out_ready does not stall the walker's registered result; each byte
// passes through a four-entry input queue and the registered result.
module class_file_structure_walker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        start_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  region,
	output logic [15:0] pool_index,
	output logic [7:0]  pool_tag,
	output logic        attr_body_first,
	output logic        attr_body_last,
	output logic [31:0] attr_length,
	output logic [1:0]  error_code
);
	import cfsw_pkg::*;

	logic      magic_en_q;
	in_item_t  qin, qout;
	out_item_t res;
	logic      qv, qr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_en_q <= 1'b1;
		end else if (cfg_we) begin
			magic_en_q <= cfg_wdata;
		end
	end

	assign qin.data_byte     = data_byte;
	assign qin.start_of_file = start_of_file;

	cfsw_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(qin),
		.out_valid(qv), .out_ready(qr), .out_item(qout)
	);

	cfsw_walker u_walker (
		.clk(clk), .arst_n(arst_n), .magic_check_enable(magic_en_q),
		.in_valid(qv), .in_ready(qr), .in_item(qout),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(res)
	);

	assign region          = res.region;
	assign pool_index      = res.pool_index;
	assign pool_tag        = res.pool_tag;
	assign attr_body_first = res.attr_body_first;
	assign attr_body_last  = res.attr_body_last;
	assign attr_length     = res.attr_length;
	assign error_code      = res.error_code;
endmodule
